>>> rtl/gmsp_pkg.sv
// ----------------------------------------------------------------------------
// gmsp_pkg
// shared types and constants of the grid max score path counter
// ----------------------------------------------------------------------------
package gmsp_pkg;

  localparam int unsigned MAX_SIDE = 128;
  localparam int unsigned COL_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CMP_W    = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

  localparam int unsigned SCORE_W  = 12;
  localparam int unsigned COUNT_W  = 30;
  localparam int unsigned SUM_W    = COUNT_W + 2;

  localparam logic [COUNT_W-1:0] COUNT_MOD   = 30'd1000000007;
  localparam logic [SCORE_W-1:0] SCORE_SAT   = 12'd4095;
  localparam logic [CFG_W-1:0]   GRID_RESET  = 8'd128;

  // apb register map
  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_GRID_SIZE = 1'b0;

  typedef enum logic [1:0] {
    KIND_DIGIT    = 2'd0,
    KIND_OBSTACLE = 2'd1,
    KIND_START    = 2'd2,
    KIND_END      = 2'd3
  } kind_e;

  // one row buffer entry: reachable flag, score and path count
  typedef struct packed {
    logic               reach;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // per-cell control handed to the evaluator
  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
    logic       corner;
  } cell_ctl_t;

endpackage

>>> rtl/gmsp_ram.sv
// ----------------------------------------------------------------------------
// gmsp_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module gmsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gmsp_cell_eval.sv
// ----------------------------------------------------------------------------
// gmsp_cell_eval
// best score and tied path count of one cell from its three neighbours
// ----------------------------------------------------------------------------
module gmsp_cell_eval
  import gmsp_pkg::*;
(
  input  entry_t    down_i,
  input  entry_t    right_i,
  input  entry_t    diag_i,
  input  cell_ctl_t ctl_i,
  output entry_t    result_o
);

  logic [SCORE_W-1:0] best;
  logic               any_reach;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   mod1;
  logic [SUM_W-1:0]   mod2;
  logic [COUNT_W-1:0] count_red;
  logic [SCORE_W:0]   score_raw;
  logic [3:0]         add_val;

  assign mod1 = {2'b00, COUNT_MOD};
  assign mod2 = {1'b0, COUNT_MOD, 1'b0};

  always_comb begin
    best      = '0;
    any_reach = down_i.reach | right_i.reach | diag_i.reach;
    if (down_i.reach && down_i.score > best) best = down_i.score;
    if (right_i.reach && right_i.score > best) best = right_i.score;
    if (diag_i.reach && diag_i.score > best) best = diag_i.score;
  end

  // tied counts; each is below the modulus so one selection reduces the sum
  always_comb begin
    sum = '0;
    if (down_i.reach && down_i.score == best) sum = sum + {2'b00, down_i.count};
    if (right_i.reach && right_i.score == best) sum = sum + {2'b00, right_i.count};
    if (diag_i.reach && diag_i.score == best) sum = sum + {2'b00, diag_i.count};
    if (sum >= mod2) begin
      count_red = COUNT_W'(sum - mod2);
    end else if (sum >= mod1) begin
      count_red = COUNT_W'(sum - mod1);
    end else begin
      count_red = COUNT_W'(sum);
    end
  end

  assign add_val   = (ctl_i.kind == KIND_END) ? 4'd0 : ctl_i.digit;
  assign score_raw = {1'b0, best} + {{(SCORE_W - 3){1'b0}}, add_val};

  always_comb begin
    result_o = '0;
    if (ctl_i.corner) begin
      result_o.reach = 1'b1;
      result_o.count = COUNT_W'(1);
    end else if (ctl_i.kind == KIND_OBSTACLE || ctl_i.kind == KIND_START) begin
      result_o = '0;
    end else if (any_reach) begin
      result_o.reach = 1'b1;
      result_o.score = score_raw[SCORE_W] ? SCORE_SAT : score_raw[SCORE_W-1:0];
      result_o.count = count_red;
    end
  end

endmodule

>>> rtl/grid_max_score_path_count_core.sv
// ----------------------------------------------------------------------------
// grid_max_score_path_count_core
// streamed max-score path counter over a square board with a one-row buffer
// ----------------------------------------------------------------------------
// throughput: one cell per cycle, with no gaps between rows or boards; the only
//   stall is a board's last cell waiting in stage 1 while the previous result
//   is still unaccepted on the master side
// result path: the top-left cell is registered into stage 1 as it is accepted,
//   with its row buffer read at the same edge, then evaluated into the output
//   register when it leaves stage 1
// reset: asynchronous, sets the side register to 128 and clears positions,
//   neighbour registers and handshakes;
//   the row buffer is never cleared, an entry is always written before it is read
module grid_max_score_path_count_core
  import gmsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // cell stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [1:0] cell_kind, [5:2] cell_digit
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // [11:0] max_score, [41:12] path_count
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  grid_size_q;
  logic              cfg_wr;
  logic [CMP_W-1:0]  grid_ext;
  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] side_m1;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_GRID_SIZE);
  assign prdata = (paddr[2] == REG_GRID_SIZE) ? {{(32 - CFG_W){1'b0}}, grid_size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_RESET;
    end else if (cfg_wr) begin
      grid_size_q <= pwdata[CFG_W-1:0];
    end
  end

  // effective side: zero acts as one, anything above the buffer size is clamped
  assign grid_ext = CMP_W'(grid_size_q);
  always_comb begin
    if (grid_size_q == '0) begin
      side = SIDE_W'(1);
    end else if (grid_ext > CMP_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(grid_ext);
    end
  end
  assign side_m1 = side - SIDE_W'(1);

  // --------------------------------------------------------------------------
  // stage 0: position tracking and row buffer read
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] row_q, row_d;
  logic             in_fire;
  logic             col_last;
  logic             row_last;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign col_last = (SIDE_W'(col_q) == side_m1);
  assign row_last = (SIDE_W'(row_q) == side_m1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + COL_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: evaluate against the buffered row and write back
  // --------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_col_zero_q;
  logic             s1_row_zero_q;
  logic             s1_last_q;
  cell_ctl_t        s1_ctl_q;
  logic             s1_stall;
  logic             s1_fire;

  entry_t right_q, right_d;
  entry_t diag_q, diag_d;
  entry_t above;
  entry_t nb_down;
  entry_t nb_right;
  entry_t nb_diag;
  entry_t result;
  logic [ENTRY_W-1:0] ram_rdata;

  logic             out_valid_q;
  logic [SCORE_W-1:0] out_score_q;
  logic [COUNT_W-1:0] out_count_q;

  // the board's last cell may only leave stage 1 once the output register is free
  assign s1_stall      = s1_valid_q & s1_last_q & out_valid_q & ~m_axis_tready;
  assign s1_fire       = s1_valid_q & ~s1_stall;
  assign s_axis_tready = ~s1_stall;

  // a column is written back when its cell leaves stage 1 and read again a full
  // row later; with at least two columns that read comes after the write, and a
  // one-column board discards its buffer reads, so no forwarding path is needed
  gmsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SIDE)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (result),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q       <= col_q;
      s1_col_zero_q  <= (col_q == '0);
      s1_row_zero_q  <= (row_q == '0);
      s1_last_q      <= col_last & row_last;
      s1_ctl_q.kind  <= kind_e'(s_axis_tdata[1:0]);
      s1_ctl_q.digit <= s_axis_tdata[5:2];
      s1_ctl_q.corner <= (col_q == '0) && (row_q == '0);
    end
  end

  // neighbours off the board count as unreachable; the bottom row ignores the buffer
  assign above    = s1_row_zero_q ? '0 : entry_t'(ram_rdata);
  assign nb_down  = above;
  assign nb_right = s1_col_zero_q ? '0 : right_q;
  assign nb_diag  = (s1_col_zero_q | s1_row_zero_q) ? '0 : diag_q;

  gmsp_cell_eval u_eval (
    .down_i   (nb_down),
    .right_i  (nb_right),
    .diag_i   (nb_diag),
    .ctl_i    (s1_ctl_q),
    .result_o (result)
  );

  always_comb begin
    right_d = right_q;
    diag_d  = diag_q;
    if (s1_fire) begin
      right_d = result;
      diag_d  = above;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      diag_q  <= '0;
    end else if (cfg_wr) begin
      right_q <= '0;
      diag_q  <= '0;
    end else begin
      right_q <= right_d;
      diag_q  <= diag_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // an unreachable top-left cell already carries zero score and count
  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_score_q <= result.score;
      out_count_q <= result.count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(48 - SCORE_W - COUNT_W){1'b0}}, out_count_q, out_score_q};

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks grid_max_score_path_count_core against a cycle-free score predictor
// ----------------------------------------------------------------------------
// boards are streamed one cell per transaction, bottom-right cell first; a
// predictor keeps its own row buffer and neighbour registers and queues the
// max score and path count due after every top-left cell. a directed plan
// covers the corner cell, blocked cells, ties, end cells, out-of-range sides
// and restarts; random boards of mostly small sides follow under three idling
// mixes, then an oversized side write that reads back as written, and one
// all-tie board that pushes the path count through the modulus
// ----------------------------------------------------------------------------
module tb;
  import gmsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 8;     // covers stage 1 and the output register
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_CELLS  = 240;
  localparam int unsigned PHASE_BOARDS = 10;
  localparam int unsigned FLAT_SIDE    = 16;
  localparam int unsigned NUM_PLAN     = 24;
  localparam int unsigned MAX_ERR_LINES = 50;

  localparam logic [PADDR_W-1:0] ADDR_GRID_SIZE = {REG_GRID_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNUSED    = 3'd4;  // no register here

  // one expected result transaction
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } best_path_t;

  typedef enum int {
    BOARD_MIXED,   // mostly digits, a few blocked, start and end cells
    BOARD_NOISE,   // any kind, any digit
    BOARD_FLAT     // zero digits only, every path ties
  } board_style_e;

  // directed plan row: optional register write before the cell, then the cell,
  // then an optional hand-typed result for cells that finish a board
  typedef struct packed {
    logic               cfg;
    logic [PADDR_W-1:0] addr;
    logic [7:0]         value;
    kind_e              kind;
    logic [3:0]         digit;
    logic               typed;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } plan_row_t;

  localparam plan_row_t PLAN [NUM_PLAN] = '{
    // side 1: every cell is the corner, so kind never matters
    '{1'b1, ADDR_GRID_SIZE, 8'd1, KIND_DIGIT,    4'd9,  1'b1, 12'd0,  30'd1},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_OBSTACLE, 4'd0,  1'b1, 12'd0,  30'd1},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_START,    4'd0,  1'b1, 12'd0,  30'd1},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_END,      4'd15, 1'b1, 12'd0,  30'd1},
    // side 0 behaves as side 1
    '{1'b1, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd15, 1'b1, 12'd0,  30'd1},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_OBSTACLE, 4'd15, 1'b1, 12'd0,  30'd1},
    // side 2, all nines: down and right tie at 9, diagonal loses
    '{1'b1, ADDR_GRID_SIZE, 8'd2, KIND_DIGIT,    4'd9,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd9,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd9,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd9,  1'b1, 12'd18, 30'd2},
    // blocked corner still counts, only the diagonal reaches the top-left
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_OBSTACLE, 4'd0,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_OBSTACLE, 4'd0,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_START,    4'd0,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd15, 1'b1, 12'd15, 30'd1},
    // blocked top-left gives zeros
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_END,      4'd0,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd5,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd7,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_OBSTACLE, 4'd9,  1'b1, 12'd0,  30'd0},
    // half a board, then a rewrite of the same side restarts it
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd3,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd4,  1'b0, 12'd0,  30'd0},
    '{1'b1, ADDR_GRID_SIZE, 8'd2, KIND_END,      4'd0,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_DIGIT,    4'd0,  1'b0, 12'd0,  30'd0},
    // write to the empty slot mid-board must not restart; three-way tie
    '{1'b1, ADDR_UNUSED,    8'd7, KIND_DIGIT,    4'd0,  1'b0, 12'd0,  30'd0},
    '{1'b0, ADDR_GRID_SIZE, 8'd0, KIND_END,      4'd9,  1'b1, 12'd0,  30'd3}
  };

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;  // [1:0] cell_kind, [5:2] cell_digit
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [47:0]        m_axis_tdata;        // [11:0] max_score, [41:12] path_count
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state: side register, one row of entries, neighbour registers
  logic [CFG_W-1:0] grid_q = GRID_RESET;
  entry_t           row_buf [MAX_SIDE];
  entry_t           right_q = '0;
  entry_t           diag_q  = '0;
  int unsigned      col_q   = 0;
  int unsigned      row_q   = 0;

  best_path_t  pending_best [$];
  best_path_t  want_best;
  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned cells_taken = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  grid_max_score_path_count_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: watchdog expired at cycle %0d", cycle_cnt);
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_cnt++;
    if (err_cnt <= MAX_ERR_LINES)
      $display("tb: mismatch in %s, got %0d, want %0d, cycle %0d",
               what, got, want, cycle_cnt);
  endtask

  // result side: random stalls, plus a long hold-off on request, counted here
  always @(negedge clk_i) begin
    if (hold_served != hold_req) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_req;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // every accepted result transaction is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_best.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, 0);
      end else begin
        want_best = pending_best.pop_front();
        if (m_axis_tdata[SCORE_W-1:0] !== want_best.score)
          report_mismatch("max_score", m_axis_tdata[SCORE_W-1:0], want_best.score);
        if (m_axis_tdata[SCORE_W +: COUNT_W] !== want_best.count)
          report_mismatch("path_count", m_axis_tdata[SCORE_W +: COUNT_W],
                          want_best.count);
      end
    end
  end

  // best score and path count of one cell; returns the board result after the
  // top-left cell
  task automatic score_cell(input kind_e kind, input logic [3:0] digit,
                            output logic emitted, output best_path_t res);
    int unsigned       side;
    int unsigned       best;
    int unsigned       total;
    logic              any;
    longint unsigned   sum;
    entry_t            above;
    entry_t            cur;
    entry_t            nbr [3];
    side = (grid_q == 0) ? 1 : (grid_q > MAX_SIDE) ? MAX_SIDE : grid_q;
    if (col_q >= side) col_q = 0;
    if (row_q >= side) row_q = 0;
    above  = (row_q > 0) ? row_buf[col_q] : '0;
    nbr[0] = above;
    nbr[1] = (col_q > 0) ? right_q : '0;
    nbr[2] = (col_q > 0 && row_q > 0) ? diag_q : '0;
    cur    = '0;
    if (row_q == 0 && col_q == 0) begin
      // bottom-right corner is the origin of every path
      cur.reach = 1'b1;
      cur.count = COUNT_W'(1);
    end else if (kind == KIND_DIGIT || kind == KIND_END) begin
      any  = 1'b0;
      best = 0;
      sum  = 0;
      foreach (nbr[i])
        if (nbr[i].reach && (!any || nbr[i].score > best)) begin
          best = nbr[i].score;
          any  = 1'b1;
        end
      if (any) begin
        foreach (nbr[i])
          if (nbr[i].reach && nbr[i].score == best) sum += nbr[i].count;
        total = best + ((kind == KIND_END) ? 0 : digit);
        if (total > SCORE_SAT) total = SCORE_SAT;
        cur.reach = 1'b1;
        cur.score = SCORE_W'(total);
        cur.count = COUNT_W'(sum % COUNT_MOD);
      end
    end
    row_buf[col_q] = cur;
    right_q        = cur;
    diag_q         = above;
    emitted        = 1'b0;
    res            = '0;
    if (col_q + 1 >= side) begin
      col_q = 0;
      if (row_q + 1 >= side) begin
        row_q   = 0;
        emitted = 1'b1;
        if (cur.reach) res = best_path_t'{cur.score, cur.count};
      end else begin
        row_q++;
      end
    end else begin
      col_q++;
    end
  endtask

  // one cell transaction, with random gaps before it
  task automatic offer_cell(input kind_e kind, input logic [3:0] digit,
                            output logic emitted, output best_path_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, digit, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    cells_taken++;
    score_cell(kind, digit, emitted, res);
  endtask

  // stop offering and let every pending result drain out of the pipeline
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_grid();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_GRID_SIZE;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(grid_q)) report_mismatch("grid_size readback", prdata, grid_q);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write while idle; a side write restarts the board
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
    wait_drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[PADDR_W-1:2] == REG_GRID_SIZE && addr[1:0] == 2'b00) begin
      grid_q  = value;
      col_q   = 0;
      row_q   = 0;
      right_q = '0;
      diag_q  = '0;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_grid();
  endtask

  task automatic play_board(input board_style_e style, input int unsigned cells,
                            input int unsigned top_digit);
    logic        emitted;
    best_path_t  res;
    logic [31:0] r;
    int unsigned p;
    kind_e       kind;
    logic [3:0]  digit;
    repeat (cells) begin
      r = $urandom;
      p = $urandom_range(99);
      case (style)
        BOARD_NOISE: begin
          kind  = kind_e'(r[1:0]);
          digit = r[5:2];
        end
        BOARD_FLAT: begin
          kind  = (p < 4) ? KIND_END : KIND_DIGIT;
          digit = '0;
        end
        default: begin
          kind  = (p < 86) ? KIND_DIGIT : (p < 93) ? KIND_OBSTACLE :
                  (p < 96) ? KIND_START : KIND_END;
          digit = 4'($urandom_range(top_digit));
        end
      endcase
      offer_cell(kind, digit, emitted, res);
      if (emitted) pending_best.push_back(res);
    end
  endtask

  // random boards, mostly small sides; now and then a board is cut short and
  // the next side write restarts it
  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    int unsigned  start_cells;
    int unsigned  boards;
    int unsigned  side;
    int unsigned  sets;
    int unsigned  cells;
    int unsigned  p;
    int unsigned  top;
    logic [7:0]   g;
    board_style_e style;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_cells = cells_taken;
    boards      = 0;
    while (cells_taken - start_cells < PHASE_CELLS || boards < PHASE_BOARDS) begin
      p = $urandom_range(99);
      if (p < 4)       g = 8'd0;
      else if (p < 12) g = 8'd1;
      else if (p < 90) g = 8'($urandom_range(6, 2));
      else if (p < 97) g = 8'($urandom_range(10, 7));
      else             g = 8'($urandom_range(16, 11));
      cfg_write(ADDR_GRID_SIZE, g);
      side = (g == 0) ? 1 : g;
      sets = $urandom_range(3, 1);
      for (int b = 0; b < sets; b++) begin
        p     = $urandom_range(99);
        style = (p < 15) ? BOARD_NOISE : (p < 30) ? BOARD_FLAT : BOARD_MIXED;
        case ($urandom_range(3))
          0:       top = 0;
          1:       top = 1;
          2:       top = 9;
          default: top = 15;
        endcase
        cells = side * side;
        if (b == sets - 1 && side > 1 && $urandom_range(99) < 10)
          cells = $urandom_range(cells - 1, 1);
        else
          boards++;
        play_board(style, cells, top);
      end
    end
  endtask

  initial begin
    plan_row_t  row;
    logic       emitted;
    best_path_t res;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // side register comes out of reset at 128, the largest effective side
    check_grid();

    tx_idle_pct = 26;
    rx_idle_pct = 73;
    for (int i = 0; i < NUM_PLAN; i++) begin
      row = PLAN[i];
      if (row.cfg) cfg_write(row.addr, row.value);
      offer_cell(row.kind, row.digit, emitted, res);
      if (emitted) pending_best.push_back(row.typed ? best_path_t'{row.score, row.count} : res);
    end

    random_phase(26, 73);
    random_phase(73, 26);

    // side 1 gives a result per cell: with the result side held off the core
    // fills up and has to stall the cell side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    cfg_write(ADDR_GRID_SIZE, 8'd1);
    hold_req++;
    play_board(BOARD_NOISE, 40, 15);

    random_phase(0, 0);

    // an oversized side reads back as written; the flat board makes every path
    // tie, so the count wraps the modulus many times
    cfg_write(ADDR_GRID_SIZE, 8'hFF);
    cfg_write(ADDR_GRID_SIZE, 8'(FLAT_SIDE));
    play_board(BOARD_FLAT, FLAT_SIDE * FLAT_SIDE, 0);

    wait_drain();
    if (err_cnt == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/gmsp_pkg.sv
rtl/gmsp_ram.sv
rtl/gmsp_cell_eval.sv
rtl/grid_max_score_path_count_core.sv
sim/tb.sv
